// ----- hw/rtl/voxel_ray_traversal_core_defines.svh -----
// Assertion macros used by the checker file.
// Needs clk and rst in the scope where a macro is used.
`ifndef VOXEL_RAY_TRAVERSAL_CORE_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_CORE_DEFINES_SVH

// same-cycle implication
`define VRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/vrt_pkg.sv -----
// Types, constants and helpers for the voxel ray traversal core.
// No dependencies.
package vrt_pkg;

  localparam int XW = 64;
  localparam int DIR_SHIFT = 14;
  localparam int MAX_OUT = 46;

  typedef logic signed [XW-1:0] xw_t;

  localparam xw_t T_INF = xw_t'(64'h1000_0000_0000_0000);

  typedef enum logic [1:0] {
    REG_EDGE = 2'd0,
    REG_CX   = 2'd1,
    REG_CY   = 2'd2,
    REG_CZ   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic               start;
    alu_op_t            op;
    xw_t                a;
    logic signed [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    xw_t  result;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BOX,
    S_SLAB,
    S_SLAB_A,
    S_SLAB_BGO,
    S_SLAB_B,
    S_POS_GO,
    S_POS,
    S_IDX_GO,
    S_IDX,
    S_BND_GO,
    S_BND,
    S_TNX_GO,
    S_TNX,
    S_TDL_GO,
    S_TDL,
    S_WALK
  } state_t;

  // divide by 2^14, truncating toward zero
  function automatic xw_t trunc_q14(input xw_t x);
    xw_t mag;
    mag = x[XW-1] ? -x : x;
    mag = mag >>> DIR_SHIFT;
    return x[XW-1] ? -mag : mag;
  endfunction

endpackage

// ----- hw/rtl/voxel_ray_traversal_core.sv -----
// Voxel ray traversal core: slab clip, start voxel search and 3D DDA walk.
// Uses vrt_pkg and vrt_alu.
//
// One ray at a time. Setup runs all divides and multiplies through one shared
// iterative unit: up to six slab divides, then per axis one multiply and at
// most one divide for the start index, and on a non-zero axis one more
// multiply and two divides for the boundary crossing. The walk then gives one
// voxel beat per cycle while the output is taken, up to 46 beats. in_ready is
// high only between rays; config writes are taken every cycle.
module voxel_ray_traversal_core #(
  parameter int GRID_N = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  voxel_ix,
  output logic [3:0]  voxel_iy,
  output logic [3:0]  voxel_iz,
  output logic [5:0]  step_number,
  output logic [31:0] entry_distance,
  output logic        last_voxel
);
  import vrt_pkg::*;

  localparam int IW = $clog2(GRID_N + 1) + 1;

  logic [30:0]        voxel_edge;
  logic signed [31:0] center [3];

  state_t state, state_next;
  alu_req_t req;
  alu_rsp_t rsp;

  xw_t o [3];
  xw_t mn [3];
  xw_t mx [3];
  xw_t tnext [3];
  xw_t tdel [3];
  logic signed [15:0] d [3];
  logic signed [IW-1:0] idx [3];
  xw_t half, edge_w, tlo, thi, tc, tmp;
  logic [1:0] ax;
  logic [5:0] n;

  logic [30:0] edge_eff;
  logic dir_zero;
  logic ax_done;
  xw_t nr, fr, tlo_n, thi_n;
  xw_t q;
  logic [1:0] sel;
  logic signed [IW-1:0] idx_step;
  xw_t tn_sel, td_sel;
  logic out_of, last, emit;

  vrt_alu u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign edge_eff  = (voxel_edge == '0) ? 31'd1 : voxel_edge;
  assign dir_zero  = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_edge <= 31'd65536;
      center[0]  <= '0;
      center[1]  <= '0;
      center[2]  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EDGE: voxel_edge <= cfg_data[30:0];
        REG_CX:   center[0]  <= cfg_data;
        REG_CY:   center[1]  <= cfg_data;
        REG_CZ:   center[2]  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // slab bounds from the second divide, and the start index clamped to GRID_N-1
  always_comb begin
    nr    = (tmp < rsp.result) ? tmp : rsp.result;
    fr    = (tmp < rsp.result) ? rsp.result : tmp;
    tlo_n = (nr > tlo) ? nr : tlo;
    thi_n = (fr < thi) ? fr : thi;
    q     = (rsp.result > xw_t'(GRID_N - 1)) ? xw_t'(GRID_N - 1) : rsp.result;
  end

  // DDA step
  always_comb begin
    if (tnext[0] < tnext[1] && tnext[0] < tnext[2]) sel = 2'd0;
    else if (tnext[1] < tnext[2])                   sel = 2'd1;
    else                                            sel = 2'd2;
    tn_sel   = tnext[sel];
    td_sel   = tdel[sel];
    idx_step = d[sel][15] ? idx[sel] - IW'(1) : idx[sel] + IW'(1);
    out_of   = (idx_step < 0) || (idx_step >= $signed(IW'(GRID_N)));
    last     = out_of || (tn_sel > thi) || (n == 6'(MAX_OUT - 1));
    emit     = (state == S_WALK) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    req        = '0;
    ax_done    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = dir_zero ? S_IDLE : S_BOX;
      end
      S_BOX: state_next = S_SLAB;
      S_SLAB: begin
        if (d[ax] == '0) begin
          if (o[ax] < mn[ax] || o[ax] > mx[ax]) begin
            state_next = S_IDLE;
          end else begin
            ax_done    = 1'b1;
            state_next = (ax == 2'd2) ? S_POS_GO : S_SLAB;
          end
        end else begin
          req.start  = 1'b1;
          req.op     = ALU_DIV;
          req.a      = (mn[ax] - o[ax]) <<< DIR_SHIFT;
          req.b      = 32'(d[ax]);
          state_next = S_SLAB_A;
        end
      end
      S_SLAB_A: if (rsp.done) state_next = S_SLAB_BGO;
      S_SLAB_BGO: begin
        req.start  = 1'b1;
        req.op     = ALU_DIV;
        req.a      = (mx[ax] - o[ax]) <<< DIR_SHIFT;
        req.b      = 32'(d[ax]);
        state_next = S_SLAB_B;
      end
      S_SLAB_B: begin
        if (rsp.done) begin
          if (tlo_n > thi_n) begin
            state_next = S_IDLE;
          end else begin
            ax_done    = 1'b1;
            state_next = (ax == 2'd2) ? S_POS_GO : S_SLAB;
          end
        end
      end
      S_POS_GO: begin
        req.start  = 1'b1;
        req.op     = ALU_MUL;
        req.a      = tlo;
        req.b      = 32'(d[ax]);
        state_next = S_POS;
      end
      S_POS: if (rsp.done) state_next = S_IDX_GO;
      S_IDX_GO: begin
        if (tmp < 0) begin
          state_next = S_BND_GO;
        end else begin
          req.start  = 1'b1;
          req.op     = ALU_DIV;
          req.a      = tmp;
          req.b      = 32'(edge_w);
          state_next = S_IDX;
        end
      end
      S_IDX: if (rsp.done) state_next = S_BND_GO;
      S_BND_GO: begin
        if (d[ax] == '0) begin
          ax_done    = 1'b1;
          state_next = (ax == 2'd2) ? S_WALK : S_POS_GO;
        end else begin
          req.start  = 1'b1;
          req.op     = ALU_MUL;
          req.a      = d[ax][15] ? xw_t'(idx[ax]) : xw_t'(idx[ax]) + xw_t'(1);
          req.b      = 32'(edge_w);
          state_next = S_BND;
        end
      end
      S_BND: if (rsp.done) state_next = S_TNX_GO;
      S_TNX_GO: begin
        req.start  = 1'b1;
        req.op     = ALU_DIV;
        req.a      = (tmp - o[ax]) <<< DIR_SHIFT;
        req.b      = 32'(d[ax]);
        state_next = S_TNX;
      end
      S_TNX: if (rsp.done) state_next = S_TDL_GO;
      S_TDL_GO: begin
        req.start  = 1'b1;
        req.op     = ALU_DIV;
        req.a      = edge_w <<< DIR_SHIFT;
        req.b      = d[ax][15] ? -32'(d[ax]) : 32'(d[ax]);
        state_next = S_TDL;
      end
      S_TDL: begin
        if (rsp.done) begin
          ax_done    = 1'b1;
          state_next = (ax == 2'd2) ? S_WALK : S_POS_GO;
        end
      end
      S_WALK: if (emit && last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (ax_done) ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
    unique case (state)
      S_IDLE: begin
        o[0]   <= xw_t'(origin_x);
        o[1]   <= xw_t'(origin_y);
        o[2]   <= xw_t'(origin_z);
        d[0]   <= dir_x;
        d[1]   <= dir_y;
        d[2]   <= dir_z;
        edge_w <= xw_t'({1'b0, edge_eff});
        half   <= (xw_t'(GRID_N) * xw_t'({1'b0, edge_eff})) >>> 1;
      end
      S_BOX: begin
        for (int i = 0; i < 3; i++) begin
          mn[i] <= xw_t'(center[i]) - half;
          mx[i] <= xw_t'(center[i]) + half;
        end
        tlo <= '0;
        thi <= T_INF;
        ax  <= 2'd0;
      end
      S_SLAB_A: if (rsp.done) tmp <= rsp.result;
      S_SLAB_B: begin
        if (rsp.done) begin
          tlo <= tlo_n;
          thi <= thi_n;
        end
      end
      S_POS_GO: begin
        tc <= tlo;
        n  <= '0;
      end
      S_POS: if (rsp.done) tmp <= o[ax] + trunc_q14(rsp.result) - mn[ax];
      S_IDX_GO: if (tmp < 0) idx[ax] <= '0;
      S_IDX: if (rsp.done) idx[ax] <= q[IW-1:0];
      S_BND_GO: begin
        if (d[ax] == '0) begin
          tnext[ax] <= T_INF;
          tdel[ax]  <= T_INF;
        end
      end
      S_BND: if (rsp.done) tmp <= mn[ax] + rsp.result;
      S_TNX: if (rsp.done) tnext[ax] <= rsp.result;
      S_TDL: if (rsp.done) tdel[ax] <= rsp.result;
      S_WALK: begin
        if (emit) begin
          idx[sel]   <= idx_step;
          tc         <= tn_sel;
          tnext[sel] <= (tn_sel >= T_INF || td_sel >= T_INF) ? T_INF : tn_sel + td_sel;
          n          <= n + 6'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      voxel_ix    <= 4'(idx[0][IW-2:0]);
      voxel_iy    <= 4'(idx[1][IW-2:0]);
      voxel_iz    <= 4'(idx[2][IW-2:0]);
      step_number <= n;
      last_voxel  <= last;
      if (tc < 0)                          entry_distance <= '0;
      else if (tc > xw_t'(64'hFFFF_FFFF))  entry_distance <= '1;
      else                                 entry_distance <= tc[31:0];
    end
  end

endmodule

// ----- hw/rtl/vrt_alu.sv -----
// Shared iterative multiply / divide unit: shift-add multiply over 32
// multiplier bits, restoring divide over 64 dividend bits. Uses vrt_pkg.
module vrt_alu (
  input  logic            clk,
  input  logic            rst,
  input  vrt_pkg::alu_req_t req,
  output vrt_pkg::alu_rsp_t rsp
);
  import vrt_pkg::*;

  logic        busy;
  logic        done;
  alu_op_t     op_r;
  logic [5:0]  cnt;
  logic        neg;
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [31:0] mb;
  logic [31:0] rem;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic        rem_ge;
  logic        last_it;
  logic [63:0] a_mag;
  logic [31:0] b_mag;

  always_comb begin
    a_mag    = req.a[63] ? 64'(-req.a) : 64'(req.a);
    b_mag    = req.b[31] ? 32'(-req.b) : 32'(req.b);
    rem_sh   = {rem, acc[63]};
    rem_diff = rem_sh - {1'b0, mb};
    rem_ge   = rem_sh >= {1'b0, mb};
    last_it  = (op_r == ALU_MUL) ? (cnt == 6'd31) : (cnt == 6'd63);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        op_r <= req.op;
        neg  <= req.a[63] ^ req.b[31];
        mb   <= b_mag;
        rem  <= '0;
        if (req.op == ALU_MUL) begin
          acc   <= '0;
          mcand <= a_mag;
        end else begin
          acc <= a_mag;
        end
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (op_r == ALU_MUL) begin
          if (mb[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          mb    <= mb >> 1;
        end else begin
          if (rem_ge) begin
            rem <= rem_diff[31:0];
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            acc <= {acc[62:0], 1'b0};
          end
        end
        if (last_it) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = neg ? -xw_t'(acc) : xw_t'(acc);

endmodule

// ----- hw/rtl/vrt_checker.sv -----
// Port-level checks for the voxel ray traversal core, bound to the top level.
// Uses the assertion macros of voxel_ray_traversal_core_defines.svh.
`include "voxel_ray_traversal_core_defines.svh"

module vrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] dir_x,
  input logic [15:0] dir_y,
  input logic [15:0] dir_z,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  voxel_ix,
  input logic [5:0]  step_number,
  input logic [31:0] entry_distance,
  input logic        last_voxel
);

  `VRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(voxel_ix) && $stable(step_number) && $stable(entry_distance),
    "output beat changed while stalled")
  `VRT_ASSERT_NEXT(a_busy_after_in,
    in_valid && in_ready && (dir_x != '0 || dir_y != '0 || dir_z != '0),
    !in_ready, "ready stayed high after a ray beat")
  `VRT_ASSERT_NOW(a_cap_last, out_valid && step_number == 6'd45, last_voxel, "beat 45 not flagged last")
  `VRT_ASSERT_NOW(a_walk_busy, out_valid && !last_voxel, !in_ready, "ready high in mid walk")

endmodule

bind voxel_ray_traversal_core vrt_checker u_vrt_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .dir_x(dir_x),
  .dir_y(dir_y),
  .dir_z(dir_z),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .voxel_ix(voxel_ix),
  .step_number(step_number),
  .entry_distance(entry_distance),
  .last_voxel(last_voxel)
);
